[rtl/rqec_pkg.sv]
// Shared types and constants for the run-qualified event counter and score block.
package rqec_pkg;

  localparam int CountBits = 16;
  localparam int OutCntW   = 16;
  localparam int ScoreW    = 15;
  localparam int DivSteps  = 15;
  localparam int StepCntW  = $clog2(DivSteps);
  localparam int LhsW      = CountBits + 22;
  localparam int DenW      = 40;
  localparam int CmpW      = (LhsW > DenW) ? LhsW : DenW;
  localparam int RunW      = 4;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;
  localparam int InDataW   = 48;
  localparam int OutDataW  = 40;

  localparam logic [21:0]          MsPerHour = 22'd3600000;
  localparam logic [ScoreW-1:0]    ScoreFull = ScoreW'(25600);
  localparam logic [RunW-1:0]      RunMax    = '1;
  localparam logic [CountBits-1:0] CountMax  = '1;

  localparam logic [15:0] RstProbThr   = 16'd39322;
  localparam logic [3:0]  RstStartRun  = 4'd2;
  localparam logic [3:0]  RstEndRun    = 4'd3;
  localparam logic [31:0] RstStartTime = 32'd0;
  localparam logic [31:0] RstMinElap   = 32'd180000;
  localparam logic [7:0]  RstPenRate   = 8'd60;

  localparam logic [CfgIdxW-1:0] CfgProbThr   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgStartRun  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgEndRun    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStartTime = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMinElap   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPenRate   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic zero;
    logic div_init;
    logic div_step;
    logic fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic upd;
    logic ge;
    logic out_busy;
  } status_t;

endpackage

[rtl/run_qualified_event_counter_score_core.sv]
// Top level of the run-qualified event counter with rate-based quality score.
//
// The slave stream takes one sample per item; tdata carries the probability in
// bits 15:0 and the millisecond timestamp in bits 47:16. The master stream
// returns one result per sample; tdata carries event_count in bits 15:0,
// the event-open flag in bit 16, event_started in bit 17 and quality in
// bits 32:18. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i; the user must write it only while the block is idle, as the block does not enforce this.
// A sample is accepted only in the idle state. It then passes through the
// multiplications, scaling and compare, the restoring divider when the
// score is recomputed, a finish step and the load of the output register.
// When no score update is due, or the score is clamped to zero, the
// divider and the finish step are skipped.
// The output register holds a result while the receiver stalls; the next
// sample is still accepted and worked on, waiting at the end only if the
// previous result has not yet been taken.
// Reset clears all counters, the score and the output valid flag, returns
// the controller to idle and loads the configuration defaults.
module run_qualified_event_counter_score_core
  import rqec_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // probability [15:0], sample time [47:16]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // event_count [15:0], open flag [16], event_started [17], quality [32:18], zero fill
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  cmd_t                cmd;
  status_t             sts;
  logic [OutCntW-1:0]  event_count;
  logic                evt_open;
  logic                event_started;
  logic [ScoreW-1:0]   quality;

  rqec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rqec_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .probability_i   (s_axis_tdata_i[15:0]),
    .sample_ts_i     (s_axis_tdata_i[47:16]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .event_count_o   (event_count),
    .evt_open_o      (evt_open),
    .event_started_o (event_started),
    .quality_o       (quality)
  );

  assign m_axis_tdata_o = {7'b0, quality, event_started, evt_open, event_count};

endmodule

[rtl/rqec_ctrl.sv]
// Sequencing state machine for the run-qualified event counter and score block.
module rqec_ctrl
  import rqec_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  state_e                state_q, state_d;
  logic [StepCntW-1:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SCALE;
      end
      ST_SCALE: begin
        if (!sts_i.upd) begin
          state_d = ST_DONE;
        end else if (sts_i.ge) begin
          cmd_o.zero = 1'b1;
          state_d    = ST_DONE;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d          = StepCntW'(DivSteps - 1);
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/rqec_dp.sv]
// Datapath: configuration, run and event counters, score divider and output register.
module rqec_dp
  import rqec_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [15:0]         probability_i,
  input  logic [31:0]         sample_ts_i,
  input  cmd_t                cmd_i,
  output status_t             sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [OutCntW-1:0]  event_count_o,
  output logic                evt_open_o,
  output logic                event_started_o,
  output logic [ScoreW-1:0]   quality_o
);

  logic [15:0] prob_thr_q;
  logic [3:0]  start_run_q, end_run_q;
  logic [31:0] start_time_q, min_elap_q;
  logic [7:0]  pen_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prob_thr_q   <= RstProbThr;
      start_run_q  <= RstStartRun;
      end_run_q    <= RstEndRun;
      start_time_q <= RstStartTime;
      min_elap_q   <= RstMinElap;
      pen_rate_q   <= RstPenRate;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgProbThr:   prob_thr_q   <= cfg_wdata_i[15:0];
        CfgStartRun:  start_run_q  <= cfg_wdata_i[3:0];
        CfgEndRun:    end_run_q    <= cfg_wdata_i[3:0];
        CfgStartTime: start_time_q <= cfg_wdata_i;
        CfgMinElap:   min_elap_q   <= cfg_wdata_i;
        CfgPenRate:   pen_rate_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  logic [RunW-1:0]      act_q, inact_q, act_d, inact_d;
  logic                 open_q, open_d, started_q, started_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [ScoreW-1:0]    score_q;
  logic [RunW-1:0]      need_on, need_off;
  logic                 active;

  always_comb begin
    need_on   = (start_run_q == '0) ? RunW'(1) : start_run_q;
    need_off  = (end_run_q == '0) ? RunW'(1) : end_run_q;
    active    = probability_i > prob_thr_q;
    act_d     = '0;
    inact_d   = '0;
    if (active) begin
      act_d = (act_q < RunMax) ? act_q + 1'b1 : act_q;
    end else begin
      inact_d = (inact_q < RunMax) ? inact_q + 1'b1 : inact_q;
    end
    open_d    = open_q;
    started_d = 1'b0;
    count_d   = count_q;
    if (act_d >= need_on && !open_q) begin
      open_d    = 1'b1;
      started_d = 1'b1;
      if (count_q < CountMax) begin
        count_d = count_q + 1'b1;
      end
    end
    if (inact_d >= need_off && open_d) begin
      open_d = 1'b0;
    end
  end

  logic [31:0]        elap_q;
  logic               upd_q;
  logic [LhsW-1:0]    lhs_q;
  logic [DenW-1:0]    den_q;
  logic [DenW-1:0]    rem_q;
  logic [DivSteps-1:0] nb_q, quo_q;
  logic [LhsW+4:0]    mul25;
  logic [DenW:0]      sh;
  logic               fits;
  logic [7:0]         rate;

  assign rate  = (pen_rate_q == '0) ? 8'd1 : pen_rate_q;
  assign mul25 = ((LhsW+5)'(lhs_q) << 4) + ((LhsW+5)'(lhs_q) << 3) + (LhsW+5)'(lhs_q);
  assign sh    = {rem_q, nb_q[DivSteps-1]};
  assign fits  = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= '0;
      inact_q   <= '0;
      open_q    <= 1'b0;
      count_q   <= '0;
      score_q   <= '0;
      started_q <= 1'b0;
      upd_q     <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        act_q     <= act_d;
        inact_q   <= inact_d;
        open_q    <= open_d;
        count_q   <= count_d;
        started_q <= started_d;
      end
      if (cmd_i.mul) begin
        upd_q <= elap_q > min_elap_q;
      end
      if (cmd_i.zero) begin
        score_q <= '0;
      end
      if (cmd_i.fin) begin
        score_q <= ScoreFull - quo_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      elap_q <= sample_ts_i - start_time_q;
    end
    if (cmd_i.mul) begin
      lhs_q <= LhsW'(count_q) * LhsW'(MsPerHour);
      den_q <= DenW'(elap_q) * DenW'(rate);
    end
    if (cmd_i.div_init) begin
      rem_q <= DenW'(mul25 >> 5);
      nb_q  <= {mul25[4:0], 10'b0};
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= fits ? DenW'(sh - {1'b0, den_q}) : DenW'(sh);
      nb_q  <= nb_q << 1;
      quo_q <= {quo_q[DivSteps-2:0], fits};
    end
  end

  assign sts_o.upd      = upd_q;
  assign sts_o.ge       = CmpW'(lhs_q) >= CmpW'(den_q);
  assign sts_o.out_busy = out_valid_o && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      event_count_o   <= OutCntW'(count_q);
      evt_open_o      <= open_q;
      event_started_o <= started_q;
      quality_o       <= score_q;
    end
  end

endmodule

[verif/tb.sv]
// Self-checking testbench for the run-qualified event counter and quality score core.
`timescale 1ns / 1ps

module tb;
  import rqec_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int TailCycles    = 40;
  localparam int MaxReports    = 10;
  localparam int BurstPairs    = 8;

  localparam longint unsigned HourMs    = 64'd3600000;
  localparam longint unsigned FullScore = 64'd25600;

  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  typedef struct packed {
    logic [31:0] ts;
    logic [15:0] prob;
  } sample_t;

  typedef struct packed {
    logic [ScoreW-1:0]  quality;
    logic               started;
    logic               evt_open;
    logic [OutCntW-1:0] count;
  } verdict_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i       = '0;
  logic [CfgDataW-1:0] cfg_wdata_i     = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  // Shadow copy of the configuration registers.
  logic [15:0] cfg_thr         = RstProbThr;
  logic [3:0]  cfg_start_run   = RstStartRun;
  logic [3:0]  cfg_end_run     = RstEndRun;
  logic [31:0] cfg_t0          = RstStartTime;
  logic [31:0] cfg_min_elapsed = RstMinElap;
  logic [7:0]  cfg_pen_rate    = RstPenRate;

  // Shadow copy of the block state.
  logic [RunW-1:0]      act_run   = '0;
  logic [RunW-1:0]      idle_run  = '0;
  logic                 open_evt  = 1'b0;
  logic [CountBits-1:0] evt_total = '0;
  logic [ScoreW-1:0]    cur_score = '0;

  sample_t     pending_samples[$];
  verdict_t    expected_verdicts[$];
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  int          tx_gap       = 0;
  int          rx_gap       = 0;
  bit          tx_calm      = 1'b0;
  bit          rx_calm      = 1'b0;
  bit          no_idle      = 1'b0;
  logic [31:0] sample_clock = '0;

  run_qualified_event_counter_score_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic verdict_t score_sample(sample_t s);
    verdict_t        v;
    logic [RunW-1:0] need_on;
    logic [RunW-1:0] need_off;
    logic [31:0]     elapsed;
    longint unsigned lhs;
    longint unsigned den;
    need_on   = (cfg_start_run == '0) ? 4'd1 : cfg_start_run;
    need_off  = (cfg_end_run == '0) ? 4'd1 : cfg_end_run;
    v.started = 1'b0;
    if (s.prob > cfg_thr) begin
      if (act_run != RunMax) act_run++;
      idle_run = '0;
    end else begin
      if (idle_run != RunMax) idle_run++;
      act_run = '0;
    end
    if (act_run >= need_on && !open_evt) begin
      open_evt  = 1'b1;
      v.started = 1'b1;
      if (evt_total != CountMax) evt_total++;
    end
    if (idle_run >= need_off && open_evt) open_evt = 1'b0;
    elapsed = s.ts - cfg_t0;
    if (elapsed > cfg_min_elapsed) begin
      lhs = 64'(evt_total) * HourMs;
      den = 64'(elapsed) * 64'((cfg_pen_rate == '0) ? 8'd1 : cfg_pen_rate);
      if (lhs >= den) cur_score = '0;
      else cur_score = ScoreW'(FullScore - (lhs * FullScore) / den);
    end
    v.count    = OutCntW'(evt_total);
    v.evt_open = open_evt;
    v.quality  = cur_score;
    return v;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    if (mismatches < MaxReports)
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgProbThr:   cfg_thr         = val[15:0];
      CfgStartRun:  cfg_start_run   = val[3:0];
      CfgEndRun:    cfg_end_run     = val[3:0];
      CfgStartTime: cfg_t0          = val;
      CfgMinElap:   cfg_min_elapsed = val;
      CfgPenRate:   cfg_pen_rate    = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] thr, input logic [3:0] srun,
                            input logic [3:0] erun, input logic [31:0] t0,
                            input logic [31:0] minel, input logic [7:0] pen);
    write_reg(CfgProbThr, 32'(thr));
    write_reg(CfgStartRun, 32'(srun));
    write_reg(CfgEndRun, 32'(erun));
    write_reg(CfgStartTime, t0);
    write_reg(CfgMinElap, minel);
    write_reg(CfgPenRate, 32'(pen));
    @(negedge clk_i);
  endtask

  task automatic push_sample(input logic [15:0] prob, input logic [31:0] ts);
    sample_t s;
    s.prob = prob;
    s.ts   = ts;
    pending_samples.push_back(s);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || s_axis_tvalid_i || expected_verdicts.size() != 0);
  endtask

  // Alternating active and inactive runs of random length, with some noise mixed in.
  task automatic queue_random(input int n);
    sample_t s;
    int      run_len;
    bit      hot;
    hot = 1'($urandom_range(0, 1));
    while (n > 0) begin
      run_len = $urandom_range(1, 18);
      for (int k = 0; k < run_len && n > 0; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          s.prob = 16'($urandom());
          s.ts   = ($urandom_range(0, 1) == 0) ? $urandom() : sample_clock;
        end else begin
          if (hot && cfg_thr != '1) s.prob = 16'($urandom_range(32'(cfg_thr) + 1, 65535));
          else s.prob = 16'($urandom_range(0, 32'(cfg_thr)));
          sample_clock += 32'($urandom_range(200, 30000));
          s.ts = sample_clock;
        end
        pending_samples.push_back(s);
        n--;
      end
      hot = !hot;
    end
  endtask

  always @(posedge clk_i) begin : driver_p
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (tx_gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        tx_gap          <= tx_gap - 1;
      end else if (pending_samples.size() != 0) begin
        s_axis_tdata_i  <= pending_samples.pop_front();
        s_axis_tvalid_i <= 1'b1;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        tx_gap <= (no_idle || tx_calm) ? 0 : $urandom_range(0, 6);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : monitor_p
    verdict_t got;
    verdict_t want;
    int       stall;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      rx_gap          <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = verdict_t'(m_axis_tdata_o[32:0]);
        if (expected_verdicts.size() == 0) begin
          flag_mismatch("result with nothing expected", 64'd0, 64'(got));
        end else begin
          want = expected_verdicts.pop_front();
          if (got.count !== want.count)
            flag_mismatch("event_count", 64'(want.count), 64'(got.count));
          if (got.evt_open !== want.evt_open)
            flag_mismatch("event open flag", 64'(want.evt_open), 64'(got.evt_open));
          if (got.started !== want.started)
            flag_mismatch("event_started", 64'(want.started), 64'(got.started));
          if (got.quality !== want.quality)
            flag_mismatch("quality", 64'(want.quality), 64'(got.quality));
        end
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        stall = (no_idle || rx_calm) ? 0 : $urandom_range(0, 6);
        rx_gap          <= stall;
        m_axis_tready_i <= (stall == 0);
      end else if (rx_gap > 0) begin
        rx_gap          <= rx_gap - 1;
        m_axis_tready_i <= (rx_gap == 1);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
      if (s_axis_tvalid_i && s_axis_tready_o)
        expected_verdicts.push_back(score_sample(sample_t'(s_axis_tdata_i)));
    end
  end

  always @(posedge clk_i) begin : watchdog_p
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus_p
    logic [15:0] thr;
    logic [3:0]  srun;
    logic [3:0]  erun;
    logic [31:0] t0;
    logic [31:0] minel;
    logic [7:0]  pen;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset configuration: threshold edge, elapsed edge, opening, closing, run saturation.
    push_sample(16'd0, 32'd0);
    push_sample(16'd39322, 32'd180000);
    push_sample(16'd39323, 32'd180001);
    push_sample(16'hFFFF, 32'd200000);
    push_sample(16'hFFFF, 32'hFFFF_FFFF);
    push_sample(16'd0, 32'd1000);
    push_sample(16'd0, 32'd2000);
    push_sample(16'd0, 32'd3000);
    for (int k = 0; k < 17; k++) push_sample(16'(50000 + k), 32'(240000 + k * 60000));
    wait_drained();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin
          thr = '0; srun = '0; erun = '0; t0 = '1; minel = '0; pen = '0;
        end
        1: begin
          thr = '1; srun = 4'd15; erun = 4'd15; t0 = '0; minel = '1; pen = 8'd255;
        end
        2: begin
          thr = 16'd32768; srun = 4'd1; erun = 4'd1; t0 = $urandom(); minel = 32'd1000;
          pen = 8'd1;
        end
        default: begin
          case ($urandom_range(0, 4))
            0:       thr = '0;
            1:       thr = '1;
            2, 3:    thr = 16'($urandom_range(20000, 50000));
            default: thr = 16'($urandom());
          endcase
          srun = 4'($urandom_range(0, 15));
          erun = 4'($urandom_range(0, 15));
          t0   = $urandom();
          case ($urandom_range(0, 3))
            0:       minel = '0;
            1:       minel = '1;
            default: minel = $urandom_range(0, 900000);
          endcase
          pen = 8'($urandom_range(0, 255));
        end
      endcase
      if (ph == 0) begin
        write_reg(CfgSpareLo, $urandom());
        write_reg(CfgSpareHi, $urandom());
      end
      set_config(thr, srun, erun, t0, minel, pen);
      case ($urandom_range(0, 2))
        0:       sample_clock = cfg_t0 - 32'($urandom_range(1, 100000));
        1:       sample_clock = cfg_t0 + 32'($urandom_range(0, 4000000));
        default: sample_clock = $urandom();
      endcase
      if (ph == 4) begin
        queue_random(35);
        wait_drained();
        queue_random(35);
      end else begin
        queue_random((ph < 3) ? 40 : 64);
      end
      wait_drained();
    end

    // Short burst of one-sample events with no idling on either side.
    set_config('0, 4'd1, 4'd1, '0, '1, 8'd60);
    no_idle = 1'b1;
    for (int k = 0; k < BurstPairs; k++) begin
      push_sample(16'($urandom_range(1, 65535)), $urandom());
      push_sample(16'd0, $urandom());
    end
    wait_drained();
    no_idle = 1'b0;

    set_config('0, 4'd1, 4'd1, '0, '0, 8'd255);
    push_sample(16'hFFFF, 32'hFFFF_FFFF);
    push_sample(16'd0, 32'hF000_0000);
    push_sample(16'd1, 32'd1);
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rqec_pkg.sv
rtl/rqec_ctrl.sv
rtl/rqec_dp.sv
rtl/run_qualified_event_counter_score_core.sv
verif/tb.sv
